### rtl/sv32ptw_pkg.sv
// sv32ptw_pkg: types and constants of the sv32 page table walker
// no dependencies; used by sv32ptw_walk, sv32_page_table_walker and the testbench

package sv32ptw_pkg;

   // access types
   localparam logic [1:0] ACC_READ  = 2'd0;
   localparam logic [1:0] ACC_WRITE = 2'd1;
   localparam logic [1:0] ACC_EXEC  = 2'd2;
   localparam logic [1:0] ACC_SCAN  = 2'd3;

   // request ops
   localparam logic OP_REQUEST = 1'b0;
   localparam logic OP_PTE     = 1'b1;

   // result kinds
   localparam logic KIND_READ   = 1'b0;
   localparam logic KIND_ANSWER = 1'b1;

   // result status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_FAULT   = 3'd1;
   localparam logic [2:0] ST_CROSS   = 3'd2;
   localparam logic [2:0] ST_DIRECT  = 3'd3;
   localparam logic [2:0] ST_IGNORED = 3'd4;

   // configuration register indexes
   localparam logic CSR_TRANSLATE_ENABLE = 1'b0;
   localparam logic CSR_ROOT_PPN         = 1'b1;

   // pte bit positions
   localparam int PTE_V = 0;
   localparam int PTE_R = 1;
   localparam int PTE_W = 2;
   localparam int PTE_X = 3;
   localparam int PTE_A = 6;
   localparam int PTE_D = 7;

   // page limits for the crossing checks
   localparam logic [22:0] SUPERPAGE_SIZE = 23'h400000;
   localparam logic [12:0] PAGE_SIZE      = 13'h1000;

   typedef enum logic [2:0] {
      PHASE_IDLE = 3'b001,
      PHASE_L1   = 3'b010,
      PHASE_L0   = 3'b100
   } phase_type;

   typedef struct packed {
      logic        op;
      logic [31:0] vaddr;
      logic [3:0]  access_len;
      logic [1:0]  access_type;
      logic [31:0] pte_word;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] read_addr;
      logic [2:0]  status;
      logic [31:0] paddr;
      logic [31:0] fault_addr;
   } rsp_type;

   typedef struct packed {
      logic        translate_enable;
      logic [21:0] root_ppn;
   } cfg_type;

endpackage

### rtl/sv32ptw_if.sv
// sv32ptw channel interfaces: request, result and configuration write
// depends on nothing; used by sv32_page_table_walker

interface sv32ptw_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [31:0] vaddr;
   logic [3:0]  access_len;
   logic [1:0]  access_type;
   logic [31:0] pte_word;

   modport source (output valid, op, vaddr, access_len, access_type, pte_word, input ready);
   modport sink   (input valid, op, vaddr, access_len, access_type, pte_word, output ready);
endinterface

interface sv32ptw_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [31:0] read_addr;
   logic [2:0]  status;
   logic [31:0] paddr;
   logic [31:0] fault_addr;

   modport source (output valid, kind, read_addr, status, paddr, fault_addr, input ready);
   modport sink   (input valid, kind, read_addr, status, paddr, fault_addr, output ready);
endinterface

interface sv32ptw_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/sv32_page_table_walker.sv
// sv32_page_table_walker: top level with input register, result register and csr
// depends on sv32ptw_pkg, sv32ptw_if.sv and sv32ptw_walk
//
//   channel   dir   handshake             payload
//   req_chan  in    valid/ready           op, vaddr, access_len, access_type, pte_word
//   rsp_chan  out   valid/ready           kind, read_addr, status, paddr, fault_addr
//   csr_chan  in    valid/ready (ready=1) index, data
//
// one transaction in, one transaction out, one per cycle while results are taken;
// the walk state is updated when an item leaves the input register, so the next item
// already sees it; the decode is one add and compare deep
// reset (synchronous, active high) clears valids, walk phase, fault address and config
// a stalled result holds in the result register while one more item waits in the
// input register; req ready drops only when both are full

module sv32_page_table_walker (
   input logic           clock,
   input logic           reset,
   sv32ptw_req_if.sink   req_chan,
   sv32ptw_rsp_if.source rsp_chan,
   sv32ptw_csr_if.sink   csr_chan
);
   import sv32ptw_pkg::*;

   // input register
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;

   // result register
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   rsp_type step_rsp;

   // configuration
   cfg_type cfg_ff, cfg_in;

   logic advance;
   logic req_fire;

   // the item in the input register moves on when the result register frees up
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_fire = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff.op          <= req_chan.op;
         in_data_ff.vaddr       <= req_chan.vaddr;
         in_data_ff.access_len  <= req_chan.access_len;
         in_data_ff.access_type <= req_chan.access_type;
         in_data_ff.pte_word    <= req_chan.pte_word;
      end
      if (advance) begin
         out_data_ff <= step_rsp;
      end
   end

   // config writes are always taken
   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_TRANSLATE_ENABLE: cfg_in.translate_enable = csr_chan.data[0];
            CSR_ROOT_PPN:         cfg_in.root_ppn         = csr_chan.data[21:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sv32ptw_walk u_walk (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .req   (in_data_ff),
      .cfg   (cfg_ff),
      .rsp   (step_rsp)
   );

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.kind       = out_data_ff.kind;
   assign rsp_chan.read_addr  = out_data_ff.read_addr;
   assign rsp_chan.status     = out_data_ff.status;
   assign rsp_chan.paddr      = out_data_ff.paddr;
   assign rsp_chan.fault_addr = out_data_ff.fault_addr;

endmodule

### rtl/sv32ptw_walk.sv
// sv32ptw_walk: walk state registers and the combinational decode of a request or pte
// depends on sv32ptw_pkg

module sv32ptw_walk (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  sv32ptw_pkg::req_type  req,
   input  sv32ptw_pkg::cfg_type  cfg,
   output sv32ptw_pkg::rsp_type  rsp
);
   import sv32ptw_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [31:0] held_vaddr_ff;
   logic [3:0]  held_len_ff;
   logic [1:0]  held_type_ff;
   logic [31:0] fault_ff, fault_in;
   logic        load_held;

   logic [31:0] base;
   logic [31:0] root_addr;
   logic [31:0] l0_addr;
   logic [31:0] pa_super;
   logic [31:0] pa_page;
   logic [22:0] end_super;
   logic [12:0] end_page;
   logic        perm_ok;
   logic        is_leaf;

   assign base      = {req.pte_word[29:10], 12'h000};
   assign root_addr = {cfg.root_ppn[19:0], 12'h000} + {20'h0, req.vaddr[31:22], 2'b00};
   assign l0_addr   = base + {20'h0, held_vaddr_ff[21:12], 2'b00};
   assign pa_super  = base + {10'h0, held_vaddr_ff[21:0]};
   assign pa_page   = base + {20'h0, held_vaddr_ff[11:0]};
   assign end_super = {1'b0, held_vaddr_ff[21:0]} + {19'h0, held_len_ff};
   assign end_page  = {1'b0, held_vaddr_ff[11:0]} + {9'h0, held_len_ff};
   assign is_leaf   = req.pte_word[PTE_R] | req.pte_word[PTE_W] | req.pte_word[PTE_X];

   always_comb begin
      unique case (held_type_ff)
         ACC_READ:  perm_ok = req.pte_word[PTE_R] & req.pte_word[PTE_A];
         ACC_WRITE: perm_ok = req.pte_word[PTE_W] & req.pte_word[PTE_A] & req.pte_word[PTE_D];
         ACC_EXEC:  perm_ok = req.pte_word[PTE_X] & req.pte_word[PTE_A];
         default:   perm_ok = 1'b1;
      endcase
   end

   always_comb begin
      phase_in      = phase_ff;
      fault_in      = fault_ff;
      load_held     = 1'b0;
      rsp.kind      = KIND_ANSWER;
      rsp.read_addr = 32'h0;
      rsp.status    = ST_IGNORED;
      rsp.paddr     = 32'h0;
      if (req.op == OP_REQUEST) begin
         if (phase_ff != PHASE_IDLE) begin
            rsp.status = ST_IGNORED;
         end else if (!cfg.translate_enable) begin
            rsp.status = ST_DIRECT;
            rsp.paddr  = req.vaddr;
         end else begin
            load_held     = 1'b1;
            phase_in      = PHASE_L1;
            rsp.kind      = KIND_READ;
            rsp.status    = ST_OK;
            rsp.read_addr = root_addr;
         end
      end else begin
         unique case (phase_ff)
            PHASE_L1: begin
               phase_in = PHASE_IDLE;
               priority if (!req.pte_word[PTE_V]) begin
                  fault_in   = held_vaddr_ff;
                  rsp.status = ST_FAULT;
               end else if (is_leaf && end_super > SUPERPAGE_SIZE) begin
                  // superpage crossing leaves the fault address alone
                  rsp.status = ST_CROSS;
               end else if (is_leaf && !perm_ok) begin
                  fault_in   = held_vaddr_ff;
                  rsp.status = ST_FAULT;
               end else if (is_leaf) begin
                  rsp.status = ST_OK;
                  rsp.paddr  = pa_super;
               end else begin
                  phase_in      = PHASE_L0;
                  rsp.kind      = KIND_READ;
                  rsp.status    = ST_OK;
                  rsp.read_addr = l0_addr;
               end
            end
            PHASE_L0: begin
               phase_in = PHASE_IDLE;
               priority if (!req.pte_word[PTE_V]) begin
                  fault_in   = held_vaddr_ff;
                  rsp.status = ST_FAULT;
               end else if (end_page > PAGE_SIZE) begin
                  fault_in   = held_vaddr_ff;
                  rsp.status = ST_CROSS;
               end else if (!perm_ok) begin
                  fault_in   = held_vaddr_ff;
                  rsp.status = ST_FAULT;
               end else begin
                  rsp.status = ST_OK;
                  rsp.paddr  = pa_page;
               end
            end
            default: begin
               rsp.status = ST_IGNORED;
            end
         endcase
      end
      rsp.fault_addr = fault_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_IDLE;
         fault_ff <= 32'h0;
      end else if (fire) begin
         phase_ff <= phase_in;
         fault_ff <= fault_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && load_held) begin
         held_vaddr_ff <= req.vaddr;
         held_len_ff   <= req.access_len;
         held_type_ff  <= req.access_type;
      end
   end

endmodule

### bench/tb_sv32_page_table_walker.sv
// testbench for sv32_page_table_walker: directed and random walks checked against
// a predictor of the walk state, the fault address and the translated address
// depends on sv32ptw_pkg, the channel interfaces in sv32ptw_if.sv and the rtl

module tb_sv32_page_table_walker;
   timeunit 1ns;
   timeprecision 1ps;

   import sv32ptw_pkg::*;

   // tracks the walk exactly as the block should and holds the answers still owed
   class translation_scoreboard;
      bit         xlate_on;
      bit [21:0]  root_page;
      phase_type  walk_state;
      bit [31:0]  walk_va;
      bit [3:0]   walk_len;
      bit [1:0]   walk_acc;
      bit [31:0]  fault_va;
      rsp_type    expected_answers[$];
      int         errors;

      function new();
         xlate_on   = 1'b0;
         root_page  = '0;
         walk_state = PHASE_IDLE;
         walk_va    = '0;
         walk_len   = '0;
         walk_acc   = ACC_READ;
         fault_va   = '0;
         errors     = 0;
      endfunction

      function void write_register(logic idx, bit [31:0] data);
         if (idx == CSR_TRANSLATE_ENABLE) begin
            xlate_on = data[0];
         end else begin
            root_page = data[21:0];
         end
      endfunction

      // final pte reached: permission check decides between translated and fault
      function rsp_type leaf_answer(bit [31:0] pte, bit [31:0] pa);
         rsp_type r;
         bit      ok;
         r = '0;
         r.kind = KIND_ANSWER;
         walk_state = PHASE_IDLE;
         case (walk_acc)
            ACC_READ:  ok = pte[PTE_R] & pte[PTE_A];
            ACC_WRITE: ok = pte[PTE_W] & pte[PTE_A] & pte[PTE_D];
            ACC_EXEC:  ok = pte[PTE_X] & pte[PTE_A];
            default:   ok = 1'b1;
         endcase
         if (!ok) begin
            fault_va = walk_va;
            r.status = ST_FAULT;
         end else begin
            r.status = ST_OK;
            r.paddr  = pa;
         end
         return r;
      endfunction

      function void note_item(req_type item);
         rsp_type   r;
         bit [31:0] pte;
         bit [31:0] base;
         bit [31:0] span;
         r = '0;
         r.kind = KIND_ANSWER;
         r.status = ST_IGNORED;
         pte  = item.pte_word;
         base = {pte[29:10], 12'h000};
         if (item.op == OP_REQUEST) begin
            if (walk_state != PHASE_IDLE) begin
               r.status = ST_IGNORED;
            end else if (!xlate_on) begin
               r.status = ST_DIRECT;
               r.paddr  = item.vaddr;
            end else begin
               walk_va    = item.vaddr;
               walk_len   = item.access_len;
               walk_acc   = item.access_type;
               walk_state = PHASE_L1;
               r.kind      = KIND_READ;
               r.status    = ST_OK;
               r.read_addr = {root_page[19:0], 12'h000}
                           + {20'h0, item.vaddr[31:22], 2'b00};
            end
         end else if (walk_state == PHASE_L1) begin
            if (!pte[PTE_V]) begin
               walk_state = PHASE_IDLE;
               fault_va   = walk_va;
               r.status   = ST_FAULT;
            end else if (pte[PTE_X:PTE_R] != 3'b000) begin
               span = {10'h0, walk_va[21:0]} + {28'h0, walk_len};
               if (span > {9'h0, SUPERPAGE_SIZE}) begin
                  // superpage crossing leaves the fault address alone
                  walk_state = PHASE_IDLE;
                  r.status   = ST_CROSS;
               end else begin
                  r = leaf_answer(pte, base + {10'h0, walk_va[21:0]});
               end
            end else begin
               walk_state  = PHASE_L0;
               r.kind      = KIND_READ;
               r.status    = ST_OK;
               r.read_addr = base + {20'h0, walk_va[21:12], 2'b00};
            end
         end else if (walk_state == PHASE_L0) begin
            walk_state = PHASE_IDLE;
            if (!pte[PTE_V]) begin
               fault_va = walk_va;
               r.status = ST_FAULT;
            end else begin
               span = {20'h0, walk_va[11:0]} + {28'h0, walk_len};
               if (span > {19'h0, PAGE_SIZE}) begin
                  fault_va = walk_va;
                  r.status = ST_CROSS;
               end else begin
                  r = leaf_answer(pte, base + {20'h0, walk_va[11:0]});
               end
            end
         end
         r.fault_addr = fault_va;
         expected_answers.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         end
      endfunction

      function void check_answer(rsp_type got);
         rsp_type want;
         if (expected_answers.size() == 0) begin
            errors++;
            $display("%0t: result with nothing expected, expected none, actual %h",
                     $time, got);
            return;
         end
         want = expected_answers.pop_front();
         compare_field("kind", 32'(want.kind), 32'(got.kind));
         compare_field("read_addr", want.read_addr, got.read_addr);
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("paddr", want.paddr, got.paddr);
         compare_field("fault_addr", want.fault_addr, got.fault_addr);
      endfunction
   endclass

   logic clock;
   logic reset;

   sv32ptw_req_if req_chan();
   sv32ptw_rsp_if rsp_chan();
   sv32ptw_csr_if csr_chan();

   translation_scoreboard book;

   // idle percentages for the sender and the receiver, changed between phases
   int send_idle_pct;
   int recv_idle_pct;

   sv32_page_table_walker DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // one transaction on the request channel; valid stays high into the next
   // item when there is no gap, so it is only lowered while idling
   task automatic send_item(req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.op          <= item.op;
      req_chan.vaddr       <= item.vaddr;
      req_chan.access_len  <= item.access_len;
      req_chan.access_type <= item.access_type;
      req_chan.pte_word    <= item.pte_word;
      do @(posedge clock); while (!req_chan.ready);
      book.note_item(item);
   endtask

   task automatic send_request(bit [31:0] va, bit [3:0] len, bit [1:0] acc);
      req_type item;
      item.op          = OP_REQUEST;
      item.vaddr       = va;
      item.access_len  = len;
      item.access_type = acc;
      item.pte_word    = $urandom;
      send_item(item);
   endtask

   task automatic send_pte(bit [31:0] word);
      req_type item;
      item.op          = OP_PTE;
      item.vaddr       = $urandom;
      item.access_len  = 4'($urandom);
      item.access_type = 2'($urandom);
      item.pte_word    = word;
      send_item(item);
   endtask

   // both registers in back-to-back transactions, valid held high in between
   task automatic set_translation(bit on, bit [21:0] root);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= CSR_TRANSLATE_ENABLE;
      csr_chan.data  <= {31'h0, on};
      do @(posedge clock); while (!csr_chan.ready);
      book.write_register(CSR_TRANSLATE_ENABLE, {31'h0, on});
      csr_chan.index <= CSR_ROOT_PPN;
      csr_chan.data  <= {10'h0, root};
      do @(posedge clock); while (!csr_chan.ready);
      book.write_register(CSR_ROOT_PPN, {10'h0, root});
      csr_chan.valid <= 1'b0;
   endtask

   // hold off the sender until every owed answer is back, then cover the latency
   task automatic drain_answers();
      req_chan.valid <= 1'b0;
      while (book.expected_answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // mostly well-formed walks: requests while idle, pte words while walking;
   // the rest is noise the block has to ignore
   function automatic req_type random_item(output bit counts);
      req_type   item;
      int        pick;
      bit [31:0] w;
      item.op          = OP_REQUEST;
      item.vaddr       = $urandom;
      item.access_len  = 4'($urandom);
      item.access_type = 2'($urandom);
      item.pte_word    = $urandom;
      if (book.walk_state == PHASE_IDLE) begin
         counts  = ($urandom_range(99) < 90);
         item.op = counts ? OP_REQUEST : OP_PTE;
         pick = $urandom_range(3);
         // aim near the end of a superpage or a 4 KiB page for crossings
         if (pick == 0) begin
            item.vaddr[21:0] = 22'(22'h3FFFFF - $urandom_range(9));
         end else if (pick == 1) begin
            item.vaddr[11:0] = 12'(12'hFFF - $urandom_range(9));
         end
         item.access_len  = ($urandom_range(4) == 0) ? 4'($urandom_range(15))
                                                      : 4'($urandom_range(8, 1));
         item.access_type = 2'($urandom_range(3));
      end else begin
         counts  = ($urandom_range(99) < 92);
         item.op = counts ? OP_PTE : OP_REQUEST;
         w = $urandom;
         pick = $urandom_range(99);
         w[PTE_V] = (pick >= 10);
         w[PTE_A] = ($urandom_range(99) < 85);
         w[PTE_D] = ($urandom_range(99) < 85);
         if (book.walk_state == PHASE_L1) begin
            if (pick < 55) begin
               w[PTE_X:PTE_R] = 3'($urandom_range(7, 1));
            end else begin
               w[PTE_X:PTE_R] = 3'b000;
            end
         end
         item.pte_word = w;
      end
      return item;
   endfunction

   // receiver: sample at the edge, check a moment later so that the item
   // accepted at the same edge has already been noted
   initial begin
      rsp_type got;
      bit      fired;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         fired = !reset && rsp_chan.valid && rsp_chan.ready;
         got.kind       = rsp_chan.kind;
         got.read_addr  = rsp_chan.read_addr;
         got.status     = rsp_chan.status;
         got.paddr      = rsp_chan.paddr;
         got.fault_addr = rsp_chan.fault_addr;
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         if (fired) begin
            #1;
            book.check_answer(got);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      req_type item;
      bit      counts;
      int      n;
      book = new();
      send_idle_pct = 18;
      recv_idle_pct = 58;
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.op          <= OP_REQUEST;
      req_chan.vaddr       <= '0;
      req_chan.access_len  <= '0;
      req_chan.access_type <= ACC_READ;
      req_chan.pte_word    <= '0;
      csr_chan.valid       <= 1'b0;
      csr_chan.index       <= CSR_TRANSLATE_ENABLE;
      csr_chan.data        <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // translation off: addresses come straight back
      set_translation(1'b0, 22'h0);
      send_request(32'hFFFF_FFFF, 4'd8, ACC_READ);
      send_request(32'h0000_0000, 4'd1, ACC_WRITE);
      drain_answers();

      set_translation(1'b1, 22'h3F_FFFF);
      // pte word with no walk under way is ignored
      send_pte(32'hFFFF_FFFF);
      // root address at the very top; a request mid-walk is ignored; superpage crossing
      send_request(32'hFFFF_FFFF, 4'd8, ACC_READ);
      send_request(32'h0000_0000, 4'd1, ACC_READ);
      send_pte(32'h0000_0043);
      // invalid level-1 entry
      send_request(32'h0040_0000, 4'd4, ACC_READ);
      send_pte(32'h0000_0000);
      // superpage write with w, a and d set, physical address wraps
      send_request(32'h1234_5678, 4'd4, ACC_WRITE);
      send_pte(32'hFFFF_FCC7);
      // execute without accessed bit
      send_request(32'h00AB_CDEF, 4'd2, ACC_EXEC);
      send_pte(32'h0000_0009);
      // two-level walk ending in an invalid level-0 entry
      send_request(32'h8000_1FFC, 4'd4, ACC_READ);
      send_pte(32'h0000_0001);
      send_pte(32'h0000_0000);
      // 4 KiB page crossing, which does set the fault address
      send_request(32'h8000_1FFD, 4'd4, ACC_SCAN);
      send_pte(32'hFFFF_FC01);
      send_pte(32'hFFFF_FFFF);
      // level-0 entry with no xwr bits fails execute, zero length
      send_request(32'h7FFF_F000, 4'd0, ACC_EXEC);
      send_pte(32'h0000_0401);
      send_pte(32'h0000_0041);
      // same kind of entry passes a scan, longest length field
      send_request(32'h0000_0123, 4'd15, ACC_SCAN);
      send_pte(32'h3FFF_FC01);
      send_pte(32'h0000_0001);
      drain_answers();

      // random phases: register settings and idle patterns change at the boundaries
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_translation(1'b1, 22'($urandom_range(22'h3F_FFFF)));
            1: set_translation(1'b0, 22'($urandom_range(22'h3F_FFFF)));
            2: begin
               send_idle_pct = 58;
               recv_idle_pct = 18;
               set_translation(1'b1, 22'h3F_FFFF);
            end
            3: set_translation(1'b1, 22'($urandom_range(22'h3F_FFFF)));
            4: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               set_translation(1'b1, 22'h0);
            end
            default: set_translation(1'b1, 22'($urandom_range(22'h3F_FFFF)));
         endcase
         n = 0;
         while (n < 105) begin
            if ($urandom_range(99) == 0) drain_answers();
            item = random_item(counts);
            send_item(item);
            if (counts) n++;
         end
         drain_answers();
      end

      if (book.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
